/* design/gzf_pkg.sv */
// shared types, constants and the sequencer microprogram for the z-factor solver
// depends on nothing; imported by gzf_ctrl, gzf_datapath and the top level
package gzf_pkg;

  localparam int QB = 30;
  localparam int DVD_W = 64 + QB;

  localparam logic signed [63:0] SATV   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SATV65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q  = 64'sd1073741824;
  localparam logic signed [63:0] E_MAX  = 64'sd22548578304;

  localparam logic signed [63:0] K_A1  = 64'sd338295644;
  localparam logic signed [63:0] K_A2  = -64'sd1123896197;
  localparam logic signed [63:0] K_A3  = -64'sd620974199;
  localparam logic signed [63:0] K_A4  = 64'sd574782277;
  localparam logic signed [63:0] K_A5  = -64'sd657473937;
  localparam logic signed [63:0] K_A6  = -64'sd112622772;
  localparam logic signed [63:0] K_A7  = 64'sd731830226;
  localparam logic signed [63:0] K_A8  = 64'sd734939224;
  localparam logic signed [63:0] K_027 = 64'sd289910292;
  localparam logic signed [63:0] K_LN2 = 64'sd744261118;

  localparam logic [3:0] N_TERMS = 4'd14;

  localparam logic [2:0] CFG_CP   = 3'd0;
  localparam logic [2:0] CFG_TC   = 3'd1;
  localparam logic [2:0] CFG_RT   = 3'd2;
  localparam logic [2:0] CFG_TOL  = 3'd3;
  localparam logic [2:0] CFG_LIM  = 3'd4;

  typedef enum logic [3:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_SHR, OP_ZINIT, OP_ZUPD, OP_EXPSEL,
    OP_OUT, OP_LOOP, OP_EXPCHK, OP_NINIT, OP_NLOOP, OP_ZBR, OP_DONE, OP_RED
  } op_t;

  typedef enum logic [5:0] {
    R_ZERO, R_ONE, R_A1, R_A2, R_A3, R_A4, R_A5, R_A6, R_A7, R_A8, R_K027,
    R_LN2, R_NVAL, R_P, R_CP, R_TC, R_RT, R_ZQ,
    R_PR, R_ITR, R_ITR3, R_BASE, R_C1, R_C2, R_C3, R_C4, R_RHO, R_RHO2,
    R_RHO5, R_E, R_T, R_T2, R_T3, R_ZN, R_ACC, R_KQ, R_RR
  } reg_t;

  typedef struct packed {
    op_t        op;
    reg_t       dst;
    reg_t       a;
    reg_t       b;
    logic [6:0] sh;
    logic [6:0] steps;
    logic       zs;
  } uinst_t;

  typedef struct packed {
    logic       accept;
    logic       go;
    op_t        op;
    reg_t       dst;
    reg_t       a;
    reg_t       b;
    logic [6:0] sh;
    logic [6:0] steps;
    logic       zs;
    logic [3:0] nval;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic conv;
    logic e_skip;
  } stat_t;

  localparam logic [5:0] LOOP_PC     = 6'd16;
  localparam logic [5:0] EXP_BODY_PC = 6'd29;
  localparam logic [5:0] EXP_END_PC  = 6'd34;
  localparam logic [5:0] FINAL_PC    = 6'd44;

  function automatic uinst_t mk(input op_t op, input reg_t dst, input reg_t a,
                                input reg_t b, input logic [6:0] sh,
                                input logic [6:0] steps, input logic zs);
    uinst_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    u.sh = sh;
    u.steps = steps;
    u.zs = zs;
    return u;
  endfunction

  function automatic uinst_t ucode(input logic [5:0] pc);
    uinst_t u;
    case (pc)
      // per-request setup
      6'd0:  u = mk(OP_DIV, R_PR, R_P, R_CP, 7'd30, 7'd54, 1'b0);
      6'd1:  u = mk(OP_DIV, R_ITR, R_TC, R_RT, 7'd30, 7'd50, 1'b0);
      6'd2:  u = mk(OP_MUL, R_T, R_ITR, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd3:  u = mk(OP_MUL, R_ITR3, R_T, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd4:  u = mk(OP_MUL, R_T, R_K027, R_PR, 7'd0, 7'd0, 1'b0);
      6'd5:  u = mk(OP_MUL, R_BASE, R_T, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd6:  u = mk(OP_MUL, R_T, R_A2, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd7:  u = mk(OP_ADD, R_T, R_A1, R_T, 7'd0, 7'd0, 1'b0);
      6'd8:  u = mk(OP_MUL, R_T2, R_A3, R_ITR3, 7'd0, 7'd0, 1'b0);
      6'd9:  u = mk(OP_ADD, R_C1, R_T, R_T2, 7'd0, 7'd0, 1'b0);
      6'd10: u = mk(OP_MUL, R_T, R_A5, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd11: u = mk(OP_ADD, R_C2, R_A4, R_T, 7'd0, 7'd0, 1'b0);
      6'd12: u = mk(OP_MUL, R_T, R_A5, R_A6, 7'd0, 7'd0, 1'b0);
      6'd13: u = mk(OP_MUL, R_C3, R_T, R_ITR, 7'd0, 7'd0, 1'b0);
      6'd14: u = mk(OP_MUL, R_C4, R_A7, R_ITR3, 7'd0, 7'd0, 1'b0);
      6'd15: u = mk(OP_ZINIT, R_ZQ, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      // substitution pass
      6'd16: u = mk(OP_LOOP, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd17: u = mk(OP_DIV, R_RHO, R_BASE, R_ZQ, 7'd0, 7'd0, 1'b1);
      6'd18: u = mk(OP_MUL, R_RHO2, R_RHO, R_RHO, 7'd0, 7'd0, 1'b0);
      6'd19: u = mk(OP_MUL, R_T, R_RHO2, R_RHO2, 7'd0, 7'd0, 1'b0);
      6'd20: u = mk(OP_MUL, R_RHO5, R_T, R_RHO, 7'd0, 7'd0, 1'b0);
      6'd21: u = mk(OP_MUL, R_E, R_A8, R_RHO2, 7'd0, 7'd0, 1'b0);
      6'd22: u = mk(OP_MUL, R_T, R_C4, R_RHO2, 7'd0, 7'd0, 1'b0);
      6'd23: u = mk(OP_ADD, R_T2, R_ONE, R_E, 7'd0, 7'd0, 1'b0);
      6'd24: u = mk(OP_MUL, R_T, R_T, R_T2, 7'd0, 7'd0, 1'b0);
      // exp(-e) by range reduction and series
      6'd25: u = mk(OP_EXPCHK, R_T2, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd26: u = mk(OP_RED, R_KQ, R_E, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd27: u = mk(OP_ADD, R_ACC, R_ONE, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd28: u = mk(OP_NINIT, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd29: u = mk(OP_MUL, R_T3, R_RR, R_ACC, 7'd0, 7'd0, 1'b0);
      6'd30: u = mk(OP_DIV, R_T3, R_T3, R_NVAL, 7'd0, 7'd32, 1'b0);
      6'd31: u = mk(OP_SUB, R_ACC, R_ONE, R_T3, 7'd0, 7'd0, 1'b0);
      6'd32: u = mk(OP_NLOOP, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd33: u = mk(OP_SHR, R_T2, R_ACC, R_KQ, 7'd0, 7'd0, 1'b0);
      // new z
      6'd34: u = mk(OP_MUL, R_T, R_T, R_T2, 7'd0, 7'd0, 1'b0);
      6'd35: u = mk(OP_MUL, R_T2, R_C1, R_RHO, 7'd0, 7'd0, 1'b0);
      6'd36: u = mk(OP_ADD, R_ZN, R_ONE, R_T2, 7'd0, 7'd0, 1'b0);
      6'd37: u = mk(OP_MUL, R_T2, R_C2, R_RHO2, 7'd0, 7'd0, 1'b0);
      6'd38: u = mk(OP_ADD, R_ZN, R_ZN, R_T2, 7'd0, 7'd0, 1'b0);
      6'd39: u = mk(OP_MUL, R_T2, R_C3, R_RHO5, 7'd0, 7'd0, 1'b0);
      6'd40: u = mk(OP_ADD, R_ZN, R_ZN, R_T2, 7'd0, 7'd0, 1'b0);
      6'd41: u = mk(OP_ADD, R_ZN, R_ZN, R_T, 7'd0, 7'd0, 1'b0);
      6'd42: u = mk(OP_ZUPD, R_ZQ, R_ZN, R_ZERO, 7'd0, 7'd0, 1'b0);
      6'd43: u = mk(OP_ZBR, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      // result
      6'd44: u = mk(OP_DIV, R_RHO, R_BASE, R_ZQ, 7'd0, 7'd0, 1'b1);
      6'd45: u = mk(OP_OUT, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
      default: u = mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 7'd0, 7'd0, 1'b0);
    endcase
    return u;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic sub);
    logic signed [64:0] s;
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    if (s > SATV65) return SATV;
    if (s < -SATV65) return -SATV;
    return s[63:0];
  endfunction

endpackage

/* design/gzf_ctrl.sv */
// sequencer for the z-factor solver: walks the microprogram, runs the pass
// and series loops, issues commands to gzf_datapath; uses gzf_pkg
module gzf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [7:0]     limit,
  input  gzf_pkg::stat_t stat,
  output gzf_pkg::cmd_t  cmd,
  output logic           out_valid
);
  import gzf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_WAIT} state_t;

  state_t     state_r;
  logic [5:0] pc_r;
  logic [7:0] pass_r;
  logic [3:0] n_r;
  logic       out_valid_r;
  uinst_t     inst;

  assign inst      = ucode(pc_r);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.accept = (state_r == S_IDLE) && start;
    cmd.op     = inst.op;
    cmd.dst    = inst.dst;
    cmd.a      = inst.a;
    cmd.b      = inst.b;
    cmd.sh     = inst.sh;
    cmd.steps  = inst.steps;
    cmd.zs     = inst.zs;
    cmd.nval   = n_r;
    if (state_r == S_FETCH) begin
      case (inst.op)
        OP_LOOP, OP_NINIT, OP_NLOOP, OP_ZBR, OP_DONE: cmd.go = 1'b0;
        OP_EXPCHK: begin
          cmd.go = stat.e_skip;
          cmd.op = OP_EXPSEL;
        end
        default: cmd.go = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      pass_r      <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            pc_r    <= '0;
            pass_r  <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          case (inst.op)
            OP_LOOP: pc_r <= (pass_r >= limit) ? FINAL_PC : pc_r + 6'd1;
            OP_EXPCHK: begin
              // trivial exponent: select 1 or 0 and skip the series
              if (stat.e_skip) begin
                pc_r    <= EXP_END_PC;
                state_r <= S_WAIT;
              end else begin
                pc_r <= pc_r + 6'd1;
              end
            end
            OP_NINIT: begin
              n_r  <= N_TERMS;
              pc_r <= pc_r + 6'd1;
            end
            OP_NLOOP: begin
              if (n_r == 4'd1) begin
                pc_r <= pc_r + 6'd1;
              end else begin
                n_r  <= n_r - 4'd1;
                pc_r <= EXP_BODY_PC;
              end
            end
            OP_ZBR: begin
              pass_r <= pass_r + 8'd1;
              pc_r   <= stat.conv ? FINAL_PC : LOOP_PC;
            end
            OP_DONE: begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: begin
              pc_r    <= pc_r + 6'd1;
              state_r <= S_WAIT;
            end
          endcase
        end
        S_WAIT: begin
          if (stat.done) state_r <= S_FETCH;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/gzf_datapath.sv */
// datapath of the z-factor solver: named q30 registers, a 4-pass 32x32
// multiplier, a bit-serial divider, an ln2 range reducer and a saturating adder; uses gzf_pkg
module gzf_datapath #(
  parameter int Z_FRAC_BITS = 30
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gzf_pkg::cmd_t  cmd,
  output gzf_pkg::stat_t stat,
  input  logic [23:0]    in_pressure,
  input  logic [23:0]    cfg_cp,
  input  logic [19:0]    cfg_tc,
  input  logic [19:0]    cfg_rt,
  input  logic [29:0]    cfg_tol,
  output logic [31:0]    out_z,
  output logic [31:0]    out_rho,
  output logic           out_conv
);
  import gzf_pkg::*;

  localparam logic [6:0] DENS_L = 7'(62 + Z_FRAC_BITS);
  localparam logic [6:0] ZF_SH  = 7'(Z_FRAC_BITS);
  localparam int         ZSH    = QB - Z_FRAC_BITS;
  localparam logic [34:0] RED_LN2 = 35'(K_LN2);

  logic signed [63:0] pr_r, itr_r, itr3_r, base_r, c1_r, c2_r, c3_r, c4_r;
  logic signed [63:0] rho_r, rho2_r, rho5_r, e_r, t_r, t2_r, t3_r, zn_r, acc_r;
  logic signed [63:0] kq_r;
  logic [31:0]        rr_r;
  logic [31:0]        zq_r;
  logic [23:0]        p_r;
  logic               conv_r;
  logic               done_r;
  logic [31:0]        out_z_r, out_rho_r;
  logic               out_conv_r;

  // multiplier
  logic               mul_run_r;
  logic [2:0]         mul_cnt_r;
  logic [61:0]        mx_r, my_r;
  logic               mneg_r;
  reg_t               mdst_r;
  logic [63:0]        pp_r;
  logic [123:0]       macc_r;
  logic [31:0]        ma, mb;
  logic [6:0]         psh;
  logic signed [63:0] mmag, mres;

  // divider
  logic               div_run_r;
  logic [6:0]         dcnt_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [31:0]        dden_r, drem_r;
  logic [61:0]        dq_r;
  logic               dovf_r;
  reg_t               ddst_r;
  logic [32:0]        rem_t;
  logic               ge;
  logic signed [63:0] dres;
  logic [6:0]         eff_l, eff_sh;

  // exponent range reduction: subtract ln2 until below it, count the steps
  logic               red_run_r;
  logic [34:0]        red_rem_r;
  logic [4:0]         red_k_r;
  logic               red_fin;

  logic signed [63:0] opa, opb;
  logic               wb_en;
  reg_t               wb_dst;
  logic signed [63:0] wb_val;
  logic               mul_fin, div_fin;

  logic [63:0]        zv, rv;
  logic [31:0]        znq, zdiff;

  function automatic logic signed [63:0] rd(input reg_t s);
    case (s)
      R_ONE:  return ONE_Q;
      R_A1:   return K_A1;
      R_A2:   return K_A2;
      R_A3:   return K_A3;
      R_A4:   return K_A4;
      R_A5:   return K_A5;
      R_A6:   return K_A6;
      R_A7:   return K_A7;
      R_A8:   return K_A8;
      R_K027: return K_027;
      R_LN2:  return K_LN2;
      R_NVAL: return 64'(cmd.nval);
      R_P:    return 64'(p_r);
      R_CP:   return 64'(cfg_cp);
      R_TC:   return 64'(cfg_tc);
      R_RT:   return 64'(cfg_rt);
      R_ZQ:   return 64'(zq_r);
      R_PR:   return pr_r;
      R_ITR:  return itr_r;
      R_ITR3: return itr3_r;
      R_BASE: return base_r;
      R_C1:   return c1_r;
      R_C2:   return c2_r;
      R_C3:   return c3_r;
      R_C4:   return c4_r;
      R_RHO:  return rho_r;
      R_RHO2: return rho2_r;
      R_RHO5: return rho5_r;
      R_E:    return e_r;
      R_T:    return t_r;
      R_T2:   return t2_r;
      R_T3:   return t3_r;
      R_ZN:   return zn_r;
      R_ACC:  return acc_r;
      R_KQ:   return kq_r;
      R_RR:   return 64'(rr_r);
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa = rd(cmd.a);
    opb = rd(cmd.b);
  end

  assign stat.done   = done_r;
  assign stat.conv   = conv_r;
  assign stat.e_skip = (e_r <= 64'sd0) || (e_r >= E_MAX);

  assign out_z    = out_z_r;
  assign out_rho  = out_rho_r;
  assign out_conv = out_conv_r;

  // partial product select
  always_comb begin
    ma  = '0;
    mb  = '0;
    psh = 7'd0;
    case (mul_cnt_r)
      3'd0: begin ma = mx_r[31:0];            mb = my_r[31:0];            end
      3'd1: begin ma = mx_r[31:0];            mb = {2'b00, my_r[61:32]};  end
      3'd2: begin ma = {2'b00, mx_r[61:32]};  mb = my_r[31:0];            end
      3'd3: begin ma = {2'b00, mx_r[61:32]};  mb = {2'b00, my_r[61:32]};  end
      default: ;
    endcase
    case (mul_cnt_r)
      3'd2, 3'd3: psh = 7'd32;
      3'd4:       psh = 7'd64;
      default:    psh = 7'd0;
    endcase
  end

  assign mmag    = (|macc_r[123:92]) ? SATV : {2'b00, macc_r[91:30]};
  assign mres    = mneg_r ? -mmag : mmag;
  assign mul_fin = mul_run_r && (mul_cnt_r == 3'd5);

  // one restoring step per cycle
  assign rem_t   = {drem_r, dvd_r[DVD_W-1]};
  assign ge      = (rem_t >= {1'b0, dden_r});
  assign dres    = ((dden_r == '0) || dovf_r) ? SATV : {2'b00, dq_r};
  assign div_fin = div_run_r && (dcnt_r == 7'd0);
  assign eff_l   = cmd.zs ? DENS_L : cmd.steps;
  assign eff_sh  = cmd.zs ? ZF_SH : cmd.sh;

  assign red_fin = red_run_r && (red_rem_r < RED_LN2);

  // new z in output format and its step from the previous one
  always_comb begin
    zv = 64'(zn_r) >> ZSH;
    if (zn_r <= 64'sd0) znq = '0;
    else if (|zv[63:32]) znq = '1;
    else znq = zv[31:0];
    zdiff = (znq >= zq_r) ? (znq - zq_r) : (zq_r - znq);
    rv = 64'(rho_r) >> (QB - 28);
  end

  always_comb begin
    wb_en  = 1'b0;
    wb_dst = cmd.dst;
    wb_val = '0;
    if (mul_fin) begin
      wb_en  = 1'b1;
      wb_dst = mdst_r;
      wb_val = mres;
    end else if (div_fin) begin
      wb_en  = 1'b1;
      wb_dst = ddst_r;
      wb_val = dres;
    end else if (red_fin) begin
      wb_en  = 1'b1;
      wb_dst = R_KQ;
      wb_val = 64'(red_k_r);
    end else if (cmd.go) begin
      case (cmd.op)
        OP_ADD: begin
          wb_en  = 1'b1;
          wb_val = sat_add(opa, opb, 1'b0);
        end
        OP_SUB: begin
          wb_en  = 1'b1;
          wb_val = sat_add(opa, opb, 1'b1);
        end
        OP_SHR: begin
          wb_en  = 1'b1;
          wb_val = opa >>> opb[4:0];
        end
        OP_EXPSEL: begin
          wb_en  = 1'b1;
          wb_val = (e_r <= 64'sd0) ? ONE_Q : 64'sd0;
        end
        default: wb_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_run_r <= 1'b0;
      div_run_r <= 1'b0;
      red_run_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r <= mul_fin || div_fin || red_fin ||
                (cmd.go && (cmd.op != OP_MUL) && (cmd.op != OP_DIV) &&
                 (cmd.op != OP_RED));
      if (cmd.go && (cmd.op == OP_MUL)) mul_run_r <= 1'b1;
      else if (mul_fin) mul_run_r <= 1'b0;
      if (cmd.go && (cmd.op == OP_DIV)) div_run_r <= 1'b1;
      else if (div_fin) div_run_r <= 1'b0;
      if (cmd.go && (cmd.op == OP_RED)) red_run_r <= 1'b1;
      else if (red_fin) red_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) p_r <= in_pressure;

    // multiplier operands and partial sums
    if (cmd.go && (cmd.op == OP_MUL)) begin
      mx_r      <= opa[63] ? 62'(-opa) : opa[61:0];
      my_r      <= opb[63] ? 62'(-opb) : opb[61:0];
      mneg_r    <= opa[63] ^ opb[63];
      mdst_r    <= cmd.dst;
      mul_cnt_r <= 3'd0;
    end else if (mul_run_r) begin
      mul_cnt_r <= mul_cnt_r + 3'd1;
      pp_r      <= ma * mb;
      if (mul_cnt_r == 3'd0) macc_r <= '0;
      else if (mul_cnt_r != 3'd5) macc_r <= macc_r + (124'(pp_r) << psh);
    end

    // divider: numerator aligned so its top bit meets the first step
    if (cmd.go && (cmd.op == OP_DIV)) begin
      dvd_r  <= {{QB{1'b0}}, opa} << (eff_sh + 7'(DVD_W) - eff_l);
      dden_r <= opb[31:0];
      drem_r <= '0;
      dq_r   <= '0;
      dovf_r <= 1'b0;
      ddst_r <= cmd.dst;
      dcnt_r <= eff_l;
    end else if (div_run_r && (dcnt_r != 7'd0)) begin
      drem_r <= ge ? 32'(rem_t - {1'b0, dden_r}) : rem_t[31:0];
      dq_r   <= {dq_r[60:0], ge};
      dovf_r <= dovf_r | dq_r[61];
      dvd_r  <= dvd_r << 1;
      dcnt_r <= dcnt_r - 7'd1;
    end

    // exponent is below 21 here, so at most 30 subtractions
    if (cmd.go && (cmd.op == OP_RED)) begin
      red_rem_r <= opa[34:0];
      red_k_r   <= '0;
    end else if (red_run_r && !red_fin) begin
      red_rem_r <= red_rem_r - RED_LN2;
      red_k_r   <= red_k_r + 5'd1;
    end
    if (red_fin) rr_r <= red_rem_r[31:0];

    if (wb_en) begin
      case (wb_dst)
        R_PR:   pr_r   <= wb_val;
        R_ITR:  itr_r  <= wb_val;
        R_ITR3: itr3_r <= wb_val;
        R_BASE: base_r <= wb_val;
        R_C1:   c1_r   <= wb_val;
        R_C2:   c2_r   <= wb_val;
        R_C3:   c3_r   <= wb_val;
        R_C4:   c4_r   <= wb_val;
        R_RHO:  rho_r  <= wb_val;
        R_RHO2: rho2_r <= wb_val;
        R_RHO5: rho5_r <= wb_val;
        R_E:    e_r    <= wb_val;
        R_T:    t_r    <= wb_val;
        R_T2:   t2_r   <= wb_val;
        R_T3:   t3_r   <= wb_val;
        R_ZN:   zn_r   <= wb_val;
        R_ACC:  acc_r  <= wb_val;
        R_KQ:   kq_r   <= wb_val;
        default: ;
      endcase
    end

    if (cmd.go) begin
      case (cmd.op)
        OP_ZINIT: begin
          zq_r   <= 32'(64'd1 << Z_FRAC_BITS);
          conv_r <= 1'b0;
        end
        OP_ZUPD: begin
          zq_r   <= znq;
          conv_r <= (zdiff < {2'b00, cfg_tol});
        end
        OP_OUT: begin
          out_z_r    <= zq_r;
          out_rho_r  <= (|rv[63:32]) ? '1 : rv[31:0];
          out_conv_r <= conv_r;
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/gas_z_factor_solver_core.sv */
// gas z-factor solver, top level: configuration registers, sequencer, datapath
// the bit-serial divider produces one quotient bit per cycle, with 14 divides per exp
// series, which is skipped when the exponent is trivial. one request at a time: busy
// is high from start until the result strobe. results cannot be stalled.
// synchronous active-low reset loads the configuration defaults and idles.
module gas_z_factor_solver_core #(
  parameter int Z_FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_pressure,
  output logic        out_valid,
  output logic [31:0] out_z_factor,
  output logic [31:0] out_reduced_density,
  output logic        out_converged,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [29:0] cfg_data
);
  import gzf_pkg::*;

  logic [23:0] cp_r;
  logic [19:0] tc_r;
  logic [19:0] rt_r;
  logic [29:0] tol_r;
  logic [7:0]  lim_r;
  cmd_t        cmd;
  stat_t       stat;
  logic        start_ok;

  assign cfg_ready = 1'b1;
  assign start_ok  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r  <= 24'd172800;
      tc_r  <= 20'd97280;
      rt_r  <= 20'd153600;
      tol_r <= 30'd1074;
      lim_r <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CP:  cp_r  <= cfg_data[23:0];
        CFG_TC:  tc_r  <= cfg_data[19:0];
        CFG_RT:  rt_r  <= cfg_data[19:0];
        CFG_TOL: tol_r <= cfg_data;
        CFG_LIM: lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gzf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_ok),
    .busy      (busy),
    .limit     (lim_r),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  gzf_datapath #(
    .Z_FRAC_BITS (Z_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_pressure (in_pressure),
    .cfg_cp      (cp_r),
    .cfg_tc      (tc_r),
    .cfg_rt      (rt_r),
    .cfg_tol     (tol_r),
    .out_z       (out_z_factor),
    .out_rho     (out_reduced_density),
    .out_conv    (out_converged)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// testbench for gas_z_factor_solver_core: drives pressures and register writes,
// predicts z, reduced density and the converged flag; depends on gzf_pkg and the rtl
module tb;
  import gzf_pkg::*;

  localparam longint SAT_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint Q_ONE   = 64'd1073741824;
  localparam longint C_A1  = 64'sd338295644;
  localparam longint C_A2  = -64'sd1123896197;
  localparam longint C_A3  = -64'sd620974199;
  localparam longint C_A4  = 64'sd574782277;
  localparam longint C_A5  = -64'sd657473937;
  localparam longint C_A6  = -64'sd112622772;
  localparam longint C_A7  = 64'sd731830226;
  localparam longint C_A8  = 64'sd734939224;
  localparam longint C_027 = 64'sd289910292;
  localparam longint C_LN2 = 64'sd744261118;
  localparam int     CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [31:0] z;
    logic [31:0] rho;
    logic        conv;
  } z_result_t;

  class z_scoreboard;
    logic [23:0] crit_p;
    logic [19:0] crit_t;
    logic [19:0] res_t;
    logic [29:0] tol;
    logic [7:0]  max_pass;
    z_result_t   pending_q[$];
    int          errors;

    function void init();
      crit_p = 24'd172800;
      crit_t = 20'd97280;
      res_t = 20'd153600;
      tol = 30'd1074;
      max_pass = 8'd100;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [29:0] val);
      case (idx)
        CFG_CP:  crit_p = val[23:0];
        CFG_TC:  crit_t = val[19:0];
        CFG_RT:  res_t = val[19:0];
        CFG_TOL: tol = val;
        CFG_LIM: max_pass = val[7:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < -SAT_MAX) return -SAT_MAX;
      return v;
    endfunction

    function longint qadd(longint a, longint b);
      return clip(clip(a) + clip(b));
    endfunction

    function longint qmul(longint a, longint b);
      logic [127:0] p;
      logic [63:0] x, y, r;
      bit neg;
      neg = (a < 0) != (b < 0);
      x = (a < 0) ? -clip(a) : clip(a);
      y = (b < 0) ? -clip(b) : clip(b);
      p = ({64'b0, x} * {64'b0, y}) >> 30;
      r = (p > 128'(SAT_MAX)) ? SAT_MAX : p[63:0];
      return neg ? -longint'(r) : longint'(r);
    endfunction

    // floor(n * 2^s / d), saturating, zero divisor saturates
    function longint qdiv(logic [63:0] n, logic [63:0] d, int s);
      logic [127:0] q;
      if (d == 0) return SAT_MAX;
      q = ({64'b0, n} << s) / {64'b0, d};
      return (q > 128'(SAT_MAX)) ? SAT_MAX : longint'(q[63:0]);
    endfunction

    function longint exp_neg(longint x);
      logic [63:0] k, r, acc;
      if (x <= 0) return Q_ONE;
      if (x >= 21 * Q_ONE) return 0;
      k = x / C_LN2;
      r = x - k * C_LN2;
      acc = Q_ONE;
      for (int n = 14; n >= 1; n--) acc = Q_ONE - ((r * acc) >> 30) / n;
      return longint'(acc >> k);
    endfunction

    function logic [63:0] to_zq(longint v);
      if (v <= 0) return 0;
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function void note_request(logic [23:0] pressure);
      longint pr, itr, itr3, base, c1, c2, c3, c4, rho, rho2, rho5, e, t4, zn;
      logic [63:0] zq, znq, diff, rho_o;
      z_result_t res;
      bit conv;
      pr = qdiv(pressure, crit_p, 30);
      itr = qdiv(crit_t, res_t, 30);
      itr3 = qmul(qmul(itr, itr), itr);
      base = qmul(qmul(C_027, pr), itr);
      c1 = qadd(qadd(C_A1, qmul(C_A2, itr)), qmul(C_A3, itr3));
      c2 = qadd(C_A4, qmul(C_A5, itr));
      c3 = qmul(qmul(C_A5, C_A6), itr);
      c4 = qmul(C_A7, itr3);
      zq = Q_ONE;
      conv = 0;
      for (int pass = 0; pass < max_pass; pass++) begin
        rho = qdiv(base, zq, 30);
        rho2 = qmul(rho, rho);
        rho5 = qmul(qmul(rho2, rho2), rho);
        e = qmul(C_A8, rho2);
        t4 = qmul(qmul(qmul(c4, rho2), qadd(Q_ONE, e)), exp_neg(e));
        zn = qadd(Q_ONE, qmul(c1, rho));
        zn = qadd(zn, qmul(c2, rho2));
        zn = qadd(zn, qmul(c3, rho5));
        zn = qadd(zn, t4);
        znq = to_zq(zn);
        diff = (znq > zq) ? znq - zq : zq - znq;
        zq = znq;
        if (diff < tol) begin
          conv = 1;
          break;
        end
      end
      rho_o = qdiv(base, zq, 30) >> 2;
      res.z = zq[31:0];
      res.rho = (rho_o > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rho_o[31:0];
      res.conv = conv;
      pending_q.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] z, logic [31:0] rho, logic conv);
      z_result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result z", z, 32'd0);
        return;
      end
      w = pending_q.pop_front();
      if (z !== w.z) report("z_factor", z, w.z);
      if (rho !== w.rho) report("reduced_density", rho, w.rho);
      if (conv !== w.conv) report("converged", 32'(conv), 32'(w.conv));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [23:0] in_pressure = 0;
  logic        out_valid;
  logic [31:0] out_z_factor;
  logic [31:0] out_reduced_density;
  logic        out_converged;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [29:0] cfg_data = 0;

  z_scoreboard sb;
  int  cycles = 0;
  bit  gaps_on = 1;

  gas_z_factor_solver_core i_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_z_factor, out_reduced_density, out_converged);

  task gap();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  task drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [29:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task send_pressure(logic [23:0] p);
    gap();
    @(negedge clk);
    start <= 1;
    in_pressure <= p;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(p);
    @(negedge clk);
    start <= 0;
  endtask

  task set_all(logic [23:0] cp, logic [19:0] tc, logic [19:0] rt, logic [29:0] tl,
               logic [7:0] lim);
    drain();
    write_reg(CFG_CP, 30'(cp));
    write_reg(CFG_TC, 30'(tc));
    write_reg(CFG_RT, 30'(rt));
    write_reg(CFG_TOL, tl);
    write_reg(CFG_LIM, 30'(lim));
  endtask

  initial begin
    logic [23:0] p;
    sb = new();
    sb.init();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // defaults, pressure extremes
    send_pressure(24'd0);
    send_pressure(24'hFFFFFF);
    send_pressure(24'd1);
    send_pressure(24'd512000);
    // zero critical pressure and zero reservoir temperature saturate the quotients
    set_all(24'd0, 20'd97280, 20'd153600, 30'd1074, 8'd5);
    send_pressure(24'd256000);
    set_all(24'd172800, 20'd97280, 20'd0, 30'd1074, 8'd5);
    send_pressure(24'd256000);
    // tolerance that can never be met
    set_all(24'd172800, 20'd97280, 20'd153600, 30'd0, 8'd3);
    send_pressure(24'd768000);
    // no passes at all
    drain();
    write_reg(CFG_LIM, 30'd0);
    send_pressure(24'd768000);
    send_pressure(24'hFFFFFF);
    // widest tolerance, longest limit
    set_all(24'hFFFFFF, 20'hFFFFF, 20'd1, 30'h3FFFFFFF, 8'd255);
    send_pressure(24'hFFFFFF);
    send_pressure(24'd1);
    set_all(24'd1, 20'd1, 20'hFFFFF, 30'd1, 8'd255);
    send_pressure(24'd0);
    send_pressure(24'd1000);
    set_all(24'd1, 20'hFFFFF, 20'd1, 30'd1, 8'd4);
    send_pressure(24'hFFFFFF);
    send_pressure(24'd12345);
    // index past the register file is ignored
    drain();
    write_reg(3'd5, 30'h2AAAAAAA);
    send_pressure(24'd500000);

    for (int ph = 0; ph < 6; ph++) begin
      set_all(24'($urandom_range(550 * 256, 800 * 256)),
              20'($urandom_range(300 * 256, 450 * 256)),
              20'($urandom_range(500 * 256, 760 * 256)),
              30'($urandom_range(1, 1 << 20)),
              8'($urandom_range(1, 30)));
      if (ph == 5) gaps_on = 0;
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 7) == 0) p = 24'($urandom);
        else p = 24'($urandom_range(0, 6000 * 256));
        send_pressure(p);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
